>>> sv/assert_macros.svh
// Assertion macros shared by the RTL of the depth-to-point unit.
// Include with the bare file name; the checks drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: label");

// Checks that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: label");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

>>> sv/dp2p_pkg.sv
// Package for the depth-to-point unit: widths, limits, register map and configuration type.
// No dependencies; every module of the unit imports it.
`timescale 1ns / 1ps
`default_nettype none

package dp2p_pkg;

    localparam int DEPTH_W      = 16;
    localparam int COL_W        = 10;
    localparam int ROW_W        = 9;
    localparam int DIM_W        = 13;
    localparam int OFS_W        = 18;
    localparam int Z8_W         = 30;
    localparam int COORD_W      = 32;
    localparam int NUM_STAGES   = 7;
    localparam int APB_ADDR_W   = 5;
    localparam int APB_DATA_W   = 32;

    localparam int DEF_FRAME_WIDTH  = 640;
    localparam int DEF_FRAME_HEIGHT = 480;

    localparam logic [DEPTH_W-1:0] DEPTH_MIN = 16'd1;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 16'd5000;

    localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        REG_CENTER_X    = 3'd0,
        REG_CENTER_Y    = 3'd1,
        REG_INV_FOCAL_X = 3'd2,
        REG_INV_FOCAL_Y = 3'd3,
        REG_DEPTH_SCALE = 3'd4,
        REG_U_COEFF     = 3'd5,
        REG_V_COEFF     = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic        [15:0] center_x;
        logic        [15:0] center_y;
        logic        [31:0] inv_focal_x;
        logic        [31:0] inv_focal_y;
        logic signed [23:0] depth_scale;
        logic signed [31:0] u_coeff;
        logic signed [31:0] v_coeff;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        center_x:    16'd20480,
        center_y:    16'd15360,
        inv_focal_x: 32'd7405116,
        inv_focal_y: 32'd7405116,
        depth_scale: 24'sd1048576,
        u_coeff:     32'sd0,
        v_coeff:     32'sd0
    };

endpackage

`default_nettype wire

>>> sv/dp2p_regs.sv
// Configuration register file of the depth-to-point unit on an APB-style port.
// Depends on dp2p_pkg for the register map and the configuration type.
`timescale 1ns / 1ps
`default_nettype none

module dp2p_regs
    import dp2p_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_CENTER_X:    cfg_next.center_x    = pwdata[15:0];
                REG_CENTER_Y:    cfg_next.center_y    = pwdata[15:0];
                REG_INV_FOCAL_X: cfg_next.inv_focal_x = pwdata;
                REG_INV_FOCAL_Y: cfg_next.inv_focal_y = pwdata;
                REG_DEPTH_SCALE: cfg_next.depth_scale = pwdata[23:0];
                REG_U_COEFF:     cfg_next.u_coeff     = pwdata;
                REG_V_COEFF:     cfg_next.v_coeff     = pwdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_CENTER_X:    prdata = {16'd0, cfg_reg.center_x};
            REG_CENTER_Y:    prdata = {16'd0, cfg_reg.center_y};
            REG_INV_FOCAL_X: prdata = cfg_reg.inv_focal_x;
            REG_INV_FOCAL_Y: prdata = cfg_reg.inv_focal_y;
            REG_DEPTH_SCALE: prdata = {8'd0, cfg_reg.depth_scale};
            REG_U_COEFF:     prdata = cfg_reg.u_coeff;
            REG_V_COEFF:     prdata = cfg_reg.v_coeff;
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/dp2p_depth.sv
// Front half of the point pipeline: range check, pixel offsets and corrected depth (four stages).
// Depends on dp2p_pkg for widths, limits and the configuration type.
`timescale 1ns / 1ps
`default_nettype none

module dp2p_depth
    import dp2p_pkg::*;
#(
    parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
)
(
    input  wire logic                     clk,
    input  wire logic [3:0]               stage_en,
    input  wire cfg_t                     cfg,
    input  wire logic [DEPTH_W-1:0]       depth_sample,
    input  wire logic [COL_W-1:0]         pixel_column,
    input  wire logic [ROW_W-1:0]         pixel_row,
    output logic signed [OFS_W-1:0]       du,
    output logic signed [OFS_W-1:0]       dv,
    output logic signed [Z8_W-1:0]        z8,
    output logic                          ok
);

    // Stage 1: offsets from the principal point and the validity check.
    logic                     ok_s1_reg, ok_s1_next;
    logic [DEPTH_W-1:0]       r_s1_reg;
    logic signed [OFS_W-1:0]  du_s1_reg, du_s1_next;
    logic signed [OFS_W-1:0]  dv_s1_reg, dv_s1_next;

    // Stage 2: squared offsets and the scaled raw depth.
    logic                     ok_s2_reg;
    logic signed [OFS_W-1:0]  du_s2_reg, dv_s2_reg;
    logic [31:0]              du2_s2_reg, du2_s2_next;
    logic [31:0]              dv2_s2_reg, dv2_s2_next;
    logic signed [40:0]       rs_s2_reg, rs_s2_next;
    logic signed [2*OFS_W-1:0] du_sq, dv_sq;

    // Stage 3: correction terms, floor of the product over 2^32.
    logic                     ok_s3_reg;
    logic signed [OFS_W-1:0]  du_s3_reg, dv_s3_reg;
    logic signed [40:0]       rs_s3_reg;
    logic signed [32:0]       tu_s3_reg, tv_s3_reg;
    logic signed [64:0]       tu_prod, tv_prod;

    // Stage 4: depth in 1/256 mm, rounded half up.
    logic                     ok_s4_reg;
    logic signed [OFS_W-1:0]  du_s4_reg, dv_s4_reg;
    logic signed [Z8_W-1:0]   z8_s4_reg;
    logic signed [41:0]       zf;

    always_comb
    begin
        ok_s1_next = (depth_sample >= DEPTH_MIN) && (depth_sample <= DEPTH_MAX)
                  && (DIM_W'(pixel_column) < DIM_W'(FRAME_WIDTH))
                  && (DIM_W'(pixel_row) < DIM_W'(FRAME_HEIGHT));
        du_s1_next = $signed({2'b00, pixel_column, 6'b000000})
                   - $signed({2'b00, cfg.center_x});
        dv_s1_next = $signed({3'b000, pixel_row, 6'b000000})
                   - $signed({2'b00, cfg.center_y});
    end

    // The squares are never negative and stay below 2^32.
    assign du_sq       = du_s1_reg * du_s1_reg;
    assign dv_sq       = dv_s1_reg * dv_s1_reg;
    assign du2_s2_next = du_sq[31:0];
    assign dv2_s2_next = dv_sq[31:0];
    assign rs_s2_next  = $signed({1'b0, r_s1_reg}) * cfg.depth_scale;

    assign tu_prod = cfg.u_coeff * $signed({1'b0, du2_s2_reg});
    assign tv_prod = cfg.v_coeff * $signed({1'b0, dv2_s2_reg});

    assign zf = rs_s3_reg + tu_s3_reg + tv_s3_reg + 42'sd2048;

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            ok_s1_reg <= ok_s1_next;
            r_s1_reg  <= depth_sample;
            du_s1_reg <= du_s1_next;
            dv_s1_reg <= dv_s1_next;
        end
        if (stage_en[1])
        begin
            ok_s2_reg  <= ok_s1_reg;
            du_s2_reg  <= du_s1_reg;
            dv_s2_reg  <= dv_s1_reg;
            du2_s2_reg <= du2_s2_next;
            dv2_s2_reg <= dv2_s2_next;
            rs_s2_reg  <= rs_s2_next;
        end
        if (stage_en[2])
        begin
            ok_s3_reg <= ok_s2_reg;
            du_s3_reg <= du_s2_reg;
            dv_s3_reg <= dv_s2_reg;
            rs_s3_reg <= rs_s2_reg;
            tu_s3_reg <= tu_prod[64:32];
            tv_s3_reg <= tv_prod[64:32];
        end
        if (stage_en[3])
        begin
            ok_s4_reg <= ok_s3_reg;
            du_s4_reg <= du_s3_reg;
            dv_s4_reg <= dv_s3_reg;
            z8_s4_reg <= zf[41:12];
        end
    end

    assign du = du_s4_reg;
    assign dv = dv_s4_reg;
    assign z8 = z8_s4_reg;
    assign ok = ok_s4_reg;

endmodule

`default_nettype wire

>>> sv/dp2p_project.sv
// Back half of the point pipeline for one axis: offset times reciprocal focal length times depth.
// Three stages; depends on dp2p_pkg for widths and saturation limits.
`timescale 1ns / 1ps
`default_nettype none

module dp2p_project
    import dp2p_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic [2:0]              stage_en,
    input  wire logic signed [OFS_W-1:0] d,
    input  wire logic [31:0]             inv,
    input  wire logic signed [Z8_W-1:0]  z8,
    output logic signed [COORD_W-1:0]    coord
);

    logic [OFS_W-1:0]  d_abs;
    logic [Z8_W-1:0]   z_abs;

    logic              neg_s5_reg, neg_s6_reg, neg_s7_reg;
    logic [45:0]       a_s5_reg, a_s5_next;
    logic [54:0]       plo_s6_reg, plo_s6_next;
    logic [54:0]       phi_s6_reg, phi_s6_next;
    logic [77:0]       full;
    logic [39:0]       mag;
    logic signed [COORD_W-1:0] coord_s7_reg, coord_s7_next;

    // Offsets lie in -65535..65472, so the magnitude fits in 16 bits.
    assign d_abs     = d[OFS_W-1] ? (~d + 1'b1) : d;
    assign z_abs     = z8[Z8_W-1] ? (~z8 + 1'b1) : z8;
    assign a_s5_next = d_abs[15:0] * z_abs;

    // The 46-bit product is split in two halves for the reciprocal multiply.
    assign plo_s6_next = a_s5_reg[22:0] * inv;
    assign phi_s6_next = a_s5_reg[45:23] * inv;

    assign full = 78'(plo_s6_reg) + (78'(phi_s6_reg) << 23) + (78'(1) << 37);
    assign mag  = full[77:38];

    always_comb
    begin
        if (neg_s6_reg)
        begin
            if (mag >= 40'h00_8000_0000)
            begin
                coord_s7_next = SAT_MIN;
            end
            else
            begin
                coord_s7_next = ~mag[31:0] + 1'b1;
            end
        end
        else
        begin
            if (mag > 40'h00_7FFF_FFFF)
            begin
                coord_s7_next = SAT_MAX;
            end
            else
            begin
                coord_s7_next = mag[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            neg_s5_reg <= d[OFS_W-1] ^ z8[Z8_W-1];
            a_s5_reg   <= a_s5_next;
        end
        if (stage_en[1])
        begin
            neg_s6_reg <= neg_s5_reg;
            plo_s6_reg <= plo_s6_next;
            phi_s6_reg <= phi_s6_next;
        end
        if (stage_en[2])
        begin
            neg_s7_reg   <= neg_s6_reg;
            coord_s7_reg <= coord_s7_next;
        end
    end

    // The sign travels along for a clean stage boundary; the final value already carries it.
    assign coord = (neg_s7_reg && coord_s7_reg > 0) ? -coord_s7_reg : coord_s7_reg;

endmodule

`default_nettype wire

>>> sv/depth_pixel_to_point_unit.sv
// Depth pixel to 3-D point unit. Each input transaction carries one raw depth sample in
// millimetres with its column and row; the unit back-projects it through a pinhole camera
// model and returns one output transaction holding x, y and corrected z in 1/256 mm, saturated
// to 32 bits, with a valid flag in tuser. Samples outside 1..5000 mm or pixels outside the
// image give an all-zero point with the flag clear. The datapath is a seven-stage register
// pipeline: one new sample is taken every clock cycle unless a stalled output has filled it,
// and a result is presented once its sample reaches the last stage register. Every stage has
// its own valid bit and advances whenever it is empty or its successor advances, so a stalled
// output only halts the stages behind it once they are full, and bubbles are squeezed out
// meanwhile. The seven stages hold the pixel offsets, the squared offsets and scaled depth,
// the lens correction terms, the rounded depth, the offset-depth product, the split multiply
// by the reciprocal focal length, and the final rounding with saturation. Camera parameters
// are programmed through the APB-style port and must only change while the pipeline is empty.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module depth_pixel_to_point_unit
    import dp2p_pkg::*;
#(
    parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // Sample stream.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [15:0] depth_sample, [25:16] pixel_column, [34:26] pixel_row, [39:35] zero
    input  wire logic [39:0]           s_tdata,

    // Point stream.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [31:0] point_x, [63:32] point_y, [95:64] point_z
    output logic [95:0]                m_tdata,
    // [0] point_valid
    output logic                       m_tuser,

    // Configuration port.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    cfg_t cfg;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] stage_en;

    logic signed [OFS_W-1:0]   du, dv;
    logic signed [Z8_W-1:0]    z8;
    logic                      ok;
    logic signed [COORD_W-1:0] point_x, point_y;

    // Depth and validity ride alongside the two projection pipelines.
    logic signed [Z8_W-1:0] z_s5_reg, z_s6_reg, z_s7_reg;
    logic                   ok_s5_reg, ok_s6_reg, ok_s7_reg;
    logic signed [COORD_W-1:0] point_z;

    dp2p_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stage enables: a stage loads when it is empty or when the stage after it moves on.
    always_comb
    begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (stage_en[0])
        begin
            valid_next[0] = s_tvalid;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (stage_en[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_en[0];

    dp2p_depth #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_depth (
        .clk          (clk),
        .stage_en     (stage_en[3:0]),
        .cfg          (cfg),
        .depth_sample (s_tdata[15:0]),
        .pixel_column (s_tdata[25:16]),
        .pixel_row    (s_tdata[34:26]),
        .du           (du),
        .dv           (dv),
        .z8           (z8),
        .ok           (ok)
    );

    dp2p_project u_proj_x (
        .clk      (clk),
        .stage_en (stage_en[6:4]),
        .d        (du),
        .inv      (cfg.inv_focal_x),
        .z8       (z8),
        .coord    (point_x)
    );

    dp2p_project u_proj_y (
        .clk      (clk),
        .stage_en (stage_en[6:4]),
        .d        (dv),
        .inv      (cfg.inv_focal_y),
        .z8       (z8),
        .coord    (point_y)
    );

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            z_s5_reg  <= z8;
            ok_s5_reg <= ok;
        end
        if (stage_en[5])
        begin
            z_s6_reg  <= z_s5_reg;
            ok_s6_reg <= ok_s5_reg;
        end
        if (stage_en[6])
        begin
            z_s7_reg  <= z_s6_reg;
            ok_s7_reg <= ok_s6_reg;
        end
    end

    // The rounded depth always fits in 30 bits, so widening it never saturates.
    assign point_z = {{(COORD_W-Z8_W){z_s7_reg[Z8_W-1]}}, z_s7_reg};

    // A rejected sample leaves the pipeline as an all-zero point.
    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tuser  = ok_s7_reg;
    assign m_tdata  = ok_s7_reg ? {point_z, point_y, point_x} : '0;

    // A rejected sample never carries a nonzero coordinate.
    `ASSERT_NEVER(a_invalid_zero, clk, rst_n, m_tvalid && !m_tuser && (m_tdata != '0))

    // The input side is only held off when every stage holds a transaction.
    `ASSERT_PROP(a_no_bubble_stall, clk, rst_n, !s_tready |-> (valid_reg == '1))

    // An accepted sample always lands in the first stage.
    `ASSERT_PROP(a_accept_lands, clk, rst_n, (s_tvalid && s_tready) |=> valid_reg[0])

endmodule

`default_nettype wire
